### sv/stsc_pkg.sv
// Package: token kinds, error codes, scan modes, result word type and keyword tables.
`default_nettype none
package stsc_pkg;

  localparam int MAX_NESTING_DEF = 8;
  localparam int OFFSET_BITS_DEF = 16;
  localparam int FIFO_DEPTH      = 4;
  localparam int MAX_RES         = 3;
  localparam int WORD_DEPTH      = 9;
  localparam int NUM_KW          = 17;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_NUMBER  = 4'd2;
  localparam logic [3:0] M_NUMDOT  = 4'd3;
  localparam logic [3:0] M_FRAC    = 4'd4;
  localparam logic [3:0] M_SLASH   = 4'd5;
  localparam logic [3:0] M_OP2     = 4'd6;
  localparam logic [3:0] M_COMMENT = 4'd7;
  localparam logic [3:0] M_STRING  = 4'd8;
  localparam logic [3:0] M_DOLLAR  = 4'd9;

  localparam logic [5:0] K_EOF      = 6'd0;
  localparam logic [5:0] K_ERROR    = 6'd1;
  localparam logic [5:0] K_IDENT    = 6'd2;
  localparam logic [5:0] K_NUMBER   = 6'd3;
  localparam logic [5:0] K_STRING   = 6'd4;
  localparam logic [5:0] K_INTERP   = 6'd5;
  localparam logic [5:0] K_LPAREN   = 6'd6;
  localparam logic [5:0] K_RPAREN   = 6'd7;
  localparam logic [5:0] K_LBRACE   = 6'd8;
  localparam logic [5:0] K_RBRACE   = 6'd9;
  localparam logic [5:0] K_SEMI     = 6'd10;
  localparam logic [5:0] K_COMMA    = 6'd11;
  localparam logic [5:0] K_DOT      = 6'd12;
  localparam logic [5:0] K_MINUS    = 6'd13;
  localparam logic [5:0] K_PLUS     = 6'd15;
  localparam logic [5:0] K_SLASH    = 6'd16;
  localparam logic [5:0] K_STAR     = 6'd17;
  localparam logic [5:0] K_BANG     = 6'd18;
  localparam logic [5:0] K_EQUAL    = 6'd20;
  localparam logic [5:0] K_LESS     = 6'd22;
  localparam logic [5:0] K_GREATER  = 6'd24;
  localparam logic [5:0] K_KEYWORD0 = 6'd26;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_CHAR     = 3'd1;
  localparam logic [2:0] E_UNTERM   = 3'd2;
  localparam logic [2:0] E_DEEP     = 3'd3;
  localparam logic [2:0] E_NO_PAREN = 3'd4;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        last;
  } token_t;

  function automatic logic letter_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic decimal_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Keyword text, first character in the top byte, zero padded.
  function automatic logic [63:0] kw_text(input logic [4:0] i);
    logic [63:0] t;
    unique case (i)
      5'd0:  t = {"and", 40'd0};
      5'd1:  t = {"class", 24'd0};
      5'd2:  t = {"else", 32'd0};
      5'd3:  t = {"false", 24'd0};
      5'd4:  t = {"for", 40'd0};
      5'd5:  t = "function";
      5'd6:  t = {"if", 48'd0};
      5'd7:  t = {"nil", 40'd0};
      5'd8:  t = {"or", 48'd0};
      5'd9:  t = {"print", 24'd0};
      5'd10: t = {"return", 16'd0};
      5'd11: t = {"super", 24'd0};
      5'd12: t = {"this", 32'd0};
      5'd13: t = {"true", 32'd0};
      5'd14: t = {"var", 40'd0};
      5'd15: t = {"while", 24'd0};
      5'd16: t = {"when", 32'd0};
      default: t = 64'd0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] i);
    logic [3:0] l;
    unique case (i)
      5'd0, 5'd4, 5'd7, 5'd14:                   l = 4'd3;
      5'd1, 5'd3, 5'd9, 5'd11, 5'd15:            l = 4'd5;
      5'd2, 5'd12, 5'd13, 5'd16:                 l = 4'd4;
      5'd5:                                      l = 4'd8;
      5'd6, 5'd8:                                l = 4'd2;
      5'd10:                                     l = 4'd6;
      default:                                   l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic [15:0] sat16_add(input logic [15:0] a, input logic [1:0] k);
    logic [16:0] s;
    s = {1'b0, a} + {15'd0, k};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage
`default_nettype wire

### sv/stsc_if.sv
// Channel interfaces: source byte input and token result output.
`default_nettype none
interface stsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface stsc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [2:0]  error_code;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic        last_of_run;
  modport source (output valid, output token_kind, output error_code, output token_start,
                  output token_length, output token_line, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input error_code, input token_start,
                input token_length, input token_line, input last_of_run, output ready);
endinterface
`default_nettype wire

### sv/source_token_scanner_unit.sv
// Top level: input byte register, scanner core and result queue.
//
//   channel   dir   payload
//   in_ch     in    source_byte
//   out_ch    out   token_kind, error_code, token_start, token_length, token_line,
//                   last_of_run
//
// One source byte is taken per cycle while the queue has room. Each byte yields zero to
// three tokens, which leave through a four-word queue at one word per cycle while the
// receiver is ready, so sustained rate is one byte per cycle unless the tokens outnumber
// the bytes or the receiver stalls. A byte waits in the input register while the queue
// lacks room for its tokens. Reset is synchronous and clears all control state.
`default_nettype none
module source_token_scanner_unit #(
  parameter int MAX_NESTING = stsc_pkg::MAX_NESTING_DEF,
  parameter int OFFSET_BITS = stsc_pkg::OFFSET_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  stsc_in_if.sink     in_ch,
  stsc_out_if.source  out_ch
);
  import stsc_pkg::*;

  logic [7:0] byte_r;
  logic       full_r;
  logic       fire;
  logic       room;
  logic [1:0] num;
  token_t     res [MAX_RES];

  assign fire = full_r && room;
  assign in_ch.ready = !full_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      full_r <= 1'b1;
    end else if (fire) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) byte_r <= in_ch.source_byte;
  end

  stsc_core #(
    .MAX_NESTING (MAX_NESTING),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .byte_i (byte_r),
    .fire_i (fire),
    .res_o  (res),
    .num_o  (num)
  );

  stsc_out_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .res_i  (res),
    .num_i  (num),
    .push_i (fire),
    .room_o (room),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

### sv/stsc_core.sv
// Scanner state and the per-byte step that yields up to three tokens.
`default_nettype none
module stsc_core #(
  parameter int MAX_NESTING = stsc_pkg::MAX_NESTING_DEF,
  parameter int OFFSET_BITS = stsc_pkg::OFFSET_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [7:0]      byte_i,
  input  wire logic            fire_i,
  output stsc_pkg::token_t     res_o [stsc_pkg::MAX_RES],
  output logic [1:0]           num_o
);
  import stsc_pkg::*;

  localparam int IDXW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [3:0] MAXN = 4'(MAX_NESTING);

  logic [3:0]             mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [15:0]            line_r, line_nxt;
  logic [OFFSET_BITS-1:0] beg_r, beg_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic [7:0]             wbuf_r [WORD_DEPTH];
  logic [7:0]             wbuf_nxt [WORD_DEPTH];
  logic [15:0]            wlen_r, wlen_nxt;
  logic [7:0]             pc_r [MAX_NESTING];
  logic [7:0]             pc_nxt [MAX_NESTING];
  logic [3:0]             depth_r, depth_nxt;

  logic [5:0]  ident_kind;
  logic [63:0] key;

  function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] a,
                                                     input logic [15:0] b);
    logic [OFFSET_BITS+16:0] s;
    s = {17'd0, a} + {{(OFFSET_BITS+1){1'b0}}, b};
    if (a == OFF_MAX || s > {17'd0, OFF_MAX}) return OFF_MAX;
    return s[OFFSET_BITS-1:0];
  endfunction

  function automatic token_t mk(input logic [5:0] k, input logic [2:0] e,
                                input logic [OFFSET_BITS-1:0] st, input logic [15:0] l,
                                input logic [15:0] ln);
    token_t t;
    logic [31:0] st32;
    st32 = 32'(st);
    t.kind = k;
    t.err = e;
    t.start = st32[15:0];
    t.len = l;
    t.line = ln;
    t.last = 1'b0;
    return t;
  endfunction

  // Keyword match on the buffered first bytes of an identifier.
  always_comb begin
    key = 64'd0;
    for (int i = 0; i < 8; i++) begin
      if (16'(i) < wlen_r) key[63-8*i -: 8] = wbuf_r[i];
    end
    ident_kind = K_IDENT;
    if (wlen_r <= 16'd8) begin
      for (int k = NUM_KW - 1; k >= 0; k--) begin
        if ({12'd0, kw_len(5'(k))} == wlen_r && kw_text(5'(k)) == key)
          ident_kind = K_KEYWORD0 + 6'(k);
      end
    end
  end

  always_comb begin
    logic       go_idle;
    logic       eof;
    logic [1:0] n;
    logic [7:0] c;
    logic [7:0] want;
    logic [5:0] base;
    logic [5:0] single;
    logic [7:0] pv;
    mode_nxt = mode_r;
    off_nxt = off_r;
    line_nxt = line_r;
    beg_nxt = beg_r;
    pend_nxt = pend_r;
    wbuf_nxt = wbuf_r;
    wlen_nxt = wlen_r;
    pc_nxt = pc_r;
    depth_nxt = depth_r;
    go_idle = 1'b0;
    eof = 1'b0;
    n = 2'd0;
    c = byte_i;
    single = K_EOF;
    pv = 8'd0;
    for (int i = 0; i < MAX_RES; i++) res_o[i] = '0;

    unique case (pend_r)
      "!":     base = K_BANG;
      "=":     base = K_EQUAL;
      "<":     base = K_LESS;
      ">":     base = K_GREATER;
      default: base = K_MINUS;
    endcase
    want = (pend_r == "-") ? 8'(">") : 8'("=");

    unique case (mode_r)
      M_IDENT: begin
        if (letter_char(c) || decimal_char(c)) begin
          if (wlen_r < 16'(WORD_DEPTH)) wbuf_nxt[wlen_r[3:0]] = c;
          wlen_nxt = sat16_add(wlen_r, 2'd1);
        end else begin
          res_o[n] = mk(ident_kind, E_NONE, beg_r, wlen_r, line_nxt); n = n + 2'd1;
          go_idle = 1'b1;
        end
      end
      M_NUMBER, M_FRAC: begin
        if (decimal_char(c)) begin
          wlen_nxt = sat16_add(wlen_r, 2'd1);
        end else if (c == "." && mode_r == M_NUMBER) begin
          mode_nxt = M_NUMDOT;
        end else begin
          res_o[n] = mk(K_NUMBER, E_NONE, beg_r, wlen_r, line_nxt); n = n + 2'd1;
          go_idle = 1'b1;
        end
      end
      M_NUMDOT: begin
        if (decimal_char(c)) begin
          wlen_nxt = sat16_add(wlen_r, 2'd2);
          mode_nxt = M_FRAC;
        end else begin
          res_o[n] = mk(K_NUMBER, E_NONE, beg_r, wlen_r, line_nxt); n = n + 2'd1;
          res_o[n] = mk(K_DOT, E_NONE, sat_off(beg_r, wlen_r), 16'd1, line_nxt);
          n = n + 2'd1;
          go_idle = 1'b1;
        end
      end
      M_SLASH: begin
        if (c == "/") begin
          mode_nxt = M_COMMENT;
        end else begin
          res_o[n] = mk(K_SLASH, E_NONE, beg_r, 16'd1, line_nxt); n = n + 2'd1;
          go_idle = 1'b1;
        end
      end
      M_OP2: begin
        if (c == want) begin
          res_o[n] = mk(base + 6'd1, E_NONE, beg_r, 16'd2, line_nxt); n = n + 2'd1;
          mode_nxt = M_IDLE;
        end else begin
          res_o[n] = mk(base, E_NONE, beg_r, 16'd1, line_nxt); n = n + 2'd1;
          go_idle = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == "\n") begin
          if (line_nxt != 16'hFFFF) line_nxt = line_nxt + 16'd1;
          mode_nxt = M_IDLE;
        end else if (c == 8'd0) begin
          go_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (c == 8'd0) begin
          res_o[n] = mk(K_ERROR, E_UNTERM, beg_r, wlen_r, line_nxt); n = n + 2'd1;
          go_idle = 1'b1;
        end else begin
          wlen_nxt = sat16_add(wlen_r, 2'd1);
          if (c == "\"") begin
            res_o[n] = mk(K_STRING, E_NONE, beg_r, wlen_nxt, line_nxt); n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else if (c == "\n") begin
            if (line_nxt != 16'hFFFF) line_nxt = line_nxt + 16'd1;
          end else if (c == "$") begin
            if (depth_r >= MAXN) begin
              res_o[n] = mk(K_ERROR, E_DEEP, beg_r, wlen_nxt, line_nxt); n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else begin
              mode_nxt = M_DOLLAR;
            end
          end
        end
      end
      M_DOLLAR: begin
        if (c == 8'd0) begin
          res_o[n] = mk(K_ERROR, E_NO_PAREN, beg_r, wlen_r, line_nxt); n = n + 2'd1;
          go_idle = 1'b1;
        end else begin
          wlen_nxt = sat16_add(wlen_r, 2'd1);
          if (c == "(" && depth_r < MAXN) begin
            pc_nxt[IDXW'(depth_r)] = 8'd1;
            depth_nxt = depth_r + 4'd1;
            res_o[n] = mk(K_INTERP, E_NONE, beg_r, wlen_nxt, line_nxt); n = n + 2'd1;
          end else begin
            if (c == "\n" && line_nxt != 16'hFFFF) line_nxt = line_nxt + 16'd1;
            res_o[n] = mk(K_ERROR, (c == "(") ? E_DEEP : E_NO_PAREN, beg_r, wlen_nxt,
                          line_nxt);
            n = n + 2'd1;
          end
          mode_nxt = M_IDLE;
        end
      end
      default: go_idle = 1'b1;
    endcase

    // Handling of the byte as the start of a new token.
    if (go_idle) begin
      mode_nxt = M_IDLE;
      if (c == 8'd0) begin
        res_o[n] = mk(K_EOF, E_NONE, off_r, 16'd0, line_nxt); n = n + 2'd1;
        eof = 1'b1;
      end else if (c == " " || c == "\r" || c == "\t") begin
        single = K_EOF;
      end else if (c == "\n") begin
        if (line_nxt != 16'hFFFF) line_nxt = line_nxt + 16'd1;
      end else begin
        beg_nxt = off_r;
        wlen_nxt = 16'd1;
        if (letter_char(c)) begin
          wbuf_nxt[0] = c;
          mode_nxt = M_IDENT;
        end else if (decimal_char(c)) begin
          mode_nxt = M_NUMBER;
        end else begin
          unique case (c)
            "(": begin
              if (depth_r > 4'd0 && depth_r <= MAXN &&
                  pc_r[IDXW'(depth_r - 4'd1)] != 8'hFF)
                pc_nxt[IDXW'(depth_r - 4'd1)] = pc_r[IDXW'(depth_r - 4'd1)] + 8'd1;
              single = K_LPAREN;
            end
            ")": begin
              single = K_RPAREN;
              if (depth_r > 4'd0 && depth_r <= MAXN) begin
                pv = pc_r[IDXW'(depth_r - 4'd1)] - 8'd1;
                pc_nxt[IDXW'(depth_r - 4'd1)] = pv;
                // Closing the interpolation resumes the string at this paren.
                if (pv == 8'd0) begin
                  depth_nxt = depth_r - 4'd1;
                  mode_nxt = M_STRING;
                  single = K_EOF;
                end
              end
            end
            "{": single = K_LBRACE;
            "}": single = K_RBRACE;
            ";": single = K_SEMI;
            ",": single = K_COMMA;
            ".": single = K_DOT;
            "+": single = K_PLUS;
            "*": single = K_STAR;
            "-", "!", "=", "<", ">": begin
              pend_nxt = c;
              mode_nxt = M_OP2;
            end
            "/": mode_nxt = M_SLASH;
            "\"": mode_nxt = M_STRING;
            default: begin
              res_o[n] = mk(K_ERROR, E_CHAR, off_r, 16'd1, line_nxt); n = n + 2'd1;
            end
          endcase
          if (single != K_EOF) begin
            res_o[n] = mk(single, E_NONE, off_r, 16'd1, line_nxt); n = n + 2'd1;
          end
        end
      end
    end

    if (eof) begin
      mode_nxt = M_IDLE;
      off_nxt = '0;
      line_nxt = 16'd1;
      beg_nxt = '0;
      pend_nxt = 8'd0;
      wlen_nxt = 16'd0;
      depth_nxt = 4'd0;
    end else begin
      off_nxt = sat_off(off_r, 16'd1);
    end
    if (n != 2'd0) res_o[n - 2'd1].last = 1'b1;
    num_o = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      off_r <= '0;
      line_r <= 16'd1;
      beg_r <= '0;
      pend_r <= 8'd0;
      wlen_r <= 16'd0;
      depth_r <= 4'd0;
    end else if (fire_i) begin
      mode_r <= mode_nxt;
      off_r <= off_nxt;
      line_r <= line_nxt;
      beg_r <= beg_nxt;
      pend_r <= pend_nxt;
      wlen_r <= wlen_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_i) begin
      wbuf_r <= wbuf_nxt;
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/stsc_out_fifo.sv
// Result queue that takes up to three tokens a cycle and hands out one.
`default_nettype none
module stsc_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire stsc_pkg::token_t res_i [stsc_pkg::MAX_RES],
  input  wire logic [1:0]       num_i,
  input  wire logic             push_i,
  output logic                  room_o,
  stsc_out_if.source            out_ch
);
  import stsc_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  token_t         mem_r [FIFO_DEPTH];
  logic [PW-1:0]  wr_r, rd_r;
  logic [PW:0]    cnt_r, cnt_nxt;
  logic           pop;
  logic [PW:0]    add;

  assign pop = out_ch.valid && out_ch.ready;
  assign add = push_i ? (PW+1)'(num_i) : '0;
  // Room is judged against this cycle's pop so the queue can stream.
  assign room_o = (cnt_r + (PW+1)'(num_i)) <= ((PW+1)'(FIFO_DEPTH) + {{PW{1'b0}}, pop});
  assign cnt_nxt = cnt_r + add - {{PW{1'b0}}, pop};

  assign out_ch.valid        = cnt_r != '0;
  assign out_ch.token_kind   = mem_r[rd_r].kind;
  assign out_ch.error_code   = mem_r[rd_r].err;
  assign out_ch.token_start  = mem_r[rd_r].start;
  assign out_ch.token_length = mem_r[rd_r].len;
  assign out_ch.token_line   = mem_r[rd_r].line;
  assign out_ch.last_of_run  = mem_r[rd_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) wr_r <= wr_r + PW'(num_i);
      if (pop) rd_r <= rd_r + PW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (push_i && 2'(i) < num_i) mem_r[wr_r + PW'(i)] <= res_i[i];
    end
  end

endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for the source token scanner: directed and random source text, checked token by token.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import stsc_pkg::*;

  localparam int NEST_LIMIT = 8;
  localparam int SCAN_IDLE    = 0;
  localparam int SCAN_IDENT   = 1;
  localparam int SCAN_NUMBER  = 2;
  localparam int SCAN_NUMDOT  = 3;
  localparam int SCAN_FRAC    = 4;
  localparam int SCAN_SLASH   = 5;
  localparam int SCAN_OP2     = 6;
  localparam int SCAN_COMMENT = 7;
  localparam int SCAN_STRING  = 8;
  localparam int SCAN_DOLLAR  = 9;

  logic clk;
  logic rst_n;
  stsc_in_if  in_ch ();
  stsc_out_if out_ch ();

  source_token_scanner_unit i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Scanner state mirrored by the token predictor.
  int          mode;
  logic [15:0] offset, line_no, tok_begin, wlen;
  logic [7:0]  op_char;
  logic [7:0]  word_buf [9];
  logic [7:0]  paren_cnt [NEST_LIMIT];
  int          depth;

  token_t pending_tokens[$];
  token_t step_tokens[$];
  int     fail_count;
  bit     idle_on;
  bit     hold_out;

  function automatic bit alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [15:0] add_sat(logic [15:0] a, int k);
    int s;
    s = a + k;
    return (s > 16'hFFFF) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void clear_scanner();
    mode = SCAN_IDLE; offset = '0; line_no = 16'd1; tok_begin = '0; op_char = '0;
    wlen = '0; depth = 0;
    foreach (word_buf[i]) word_buf[i] = '0;
    foreach (paren_cnt[i]) paren_cnt[i] = '0;
  endfunction

  function automatic void emit(logic [5:0] kind, logic [2:0] err, logic [15:0] st,
                               logic [15:0] ln);
    token_t t;
    t.kind = kind; t.err = err; t.start = st; t.len = ln; t.line = line_no; t.last = 1'b0;
    if (step_tokens.size() < MAX_RES) step_tokens.push_back(t);
  endfunction

  function automatic logic [5:0] word_kind();
    string kws [17] = '{"and", "class", "else", "false", "for", "function", "if", "nil",
                        "or", "print", "return", "super", "this", "true", "var", "while",
                        "when"};
    string w;
    bit    same;
    if (wlen > 8) return K_IDENT;
    for (int i = 0; i < 17; i++) begin
      w = kws[i];
      if (w.len() != wlen) continue;
      same = 1;
      for (int j = 0; j < w.len(); j++) if (w[j] != word_buf[j]) same = 0;
      if (same) return K_KEYWORD0 + 6'(i);
    end
    return K_IDENT;
  endfunction

  // Handles a byte seen between tokens; returns 1 when it ended the source.
  function automatic bit scan_between(logic [7:0] c);
    logic [5:0] single;
    if (c == 0) begin
      emit(K_EOF, E_NONE, offset, 16'd0);
      clear_scanner();
      return 1;
    end
    if (c == " " || c == 8'h0D || c == 8'h09) return 0;
    if (c == 8'h0A) begin
      line_no = add_sat(line_no, 1);
      return 0;
    end
    tok_begin = offset; wlen = 16'd1;
    if (alpha_ch(c)) begin
      word_buf[0] = c; mode = SCAN_IDENT; return 0;
    end
    if (digit_ch(c)) begin
      mode = SCAN_NUMBER; return 0;
    end
    case (c)
      "(": begin
        if (depth > 0 && paren_cnt[depth-1] < 255) paren_cnt[depth-1]++;
        single = K_LPAREN;
      end
      ")": begin
        single = K_RPAREN;
        if (depth > 0) begin
          paren_cnt[depth-1] = paren_cnt[depth-1] - 8'd1;
          if (paren_cnt[depth-1] == 0) begin
            depth--; mode = SCAN_STRING; return 0;
          end
        end
      end
      "{": single = K_LBRACE;
      "}": single = K_RBRACE;
      ";": single = K_SEMI;
      ",": single = K_COMMA;
      ".": single = K_DOT;
      "+": single = K_PLUS;
      "*": single = K_STAR;
      "-", "!", "=", "<", ">": begin
        op_char = c; mode = SCAN_OP2; return 0;
      end
      "/": begin
        mode = SCAN_SLASH; return 0;
      end
      "\"": begin
        mode = SCAN_STRING; return 0;
      end
      default: begin
        emit(K_ERROR, E_CHAR, tok_begin, 16'd1); return 0;
      end
    endcase
    emit(single, E_NONE, tok_begin, 16'd1);
    return 0;
  endfunction

  task automatic predict_tokens(logic [7:0] c);
    bit         to_idle, ended;
    logic [7:0] want;
    logic [5:0] base;
    step_tokens.delete();
    to_idle = 0; ended = 0;
    case (mode)
      SCAN_IDENT:
        if (alpha_ch(c) || digit_ch(c)) begin
          if (wlen < 9) word_buf[wlen] = c;
          wlen = add_sat(wlen, 1);
        end else begin
          emit(word_kind(), E_NONE, tok_begin, wlen); to_idle = 1;
        end
      SCAN_NUMBER, SCAN_FRAC:
        if (digit_ch(c)) wlen = add_sat(wlen, 1);
        else if (c == "." && mode == SCAN_NUMBER) mode = SCAN_NUMDOT;
        else begin
          emit(K_NUMBER, E_NONE, tok_begin, wlen); to_idle = 1;
        end
      SCAN_NUMDOT:
        if (digit_ch(c)) begin
          wlen = add_sat(wlen, 2); mode = SCAN_FRAC;
        end else begin
          emit(K_NUMBER, E_NONE, tok_begin, wlen);
          emit(K_DOT, E_NONE, add_sat(tok_begin, wlen), 16'd1);
          to_idle = 1;
        end
      SCAN_SLASH:
        if (c == "/") mode = SCAN_COMMENT;
        else begin
          emit(K_SLASH, E_NONE, tok_begin, 16'd1); to_idle = 1;
        end
      SCAN_OP2: begin
        want = (op_char == "-") ? ">" : "=";
        case (op_char)
          "!": base = K_BANG;
          "=": base = K_EQUAL;
          "<": base = K_LESS;
          ">": base = K_GREATER;
          default: base = K_MINUS;
        endcase
        if (c == want) begin
          emit(base + 6'd1, E_NONE, tok_begin, 16'd2); mode = SCAN_IDLE;
        end else begin
          emit(base, E_NONE, tok_begin, 16'd1); to_idle = 1;
        end
      end
      SCAN_COMMENT:
        if (c == 8'h0A) begin
          line_no = add_sat(line_no, 1); mode = SCAN_IDLE;
        end else if (c == 0) to_idle = 1;
      SCAN_STRING:
        if (c == 0) begin
          emit(K_ERROR, E_UNTERM, tok_begin, wlen); to_idle = 1;
        end else begin
          wlen = add_sat(wlen, 1);
          if (c == "\"") begin
            emit(K_STRING, E_NONE, tok_begin, wlen); mode = SCAN_IDLE;
          end else if (c == 8'h0A) line_no = add_sat(line_no, 1);
          else if (c == "$") begin
            if (depth >= NEST_LIMIT) begin
              emit(K_ERROR, E_DEEP, tok_begin, wlen); mode = SCAN_IDLE;
            end else mode = SCAN_DOLLAR;
          end
        end
      SCAN_DOLLAR:
        if (c == 0) begin
          emit(K_ERROR, E_NO_PAREN, tok_begin, wlen); to_idle = 1;
        end else begin
          wlen = add_sat(wlen, 1);
          if (c == "(" && depth < NEST_LIMIT) begin
            paren_cnt[depth] = 8'd1; depth++;
            emit(K_INTERP, E_NONE, tok_begin, wlen);
          end else begin
            if (c == 8'h0A) line_no = add_sat(line_no, 1);
            emit(K_ERROR, (c == "(") ? E_DEEP : E_NO_PAREN, tok_begin, wlen);
          end
          mode = SCAN_IDLE;
        end
      default: to_idle = 1;
    endcase
    if (to_idle) begin
      mode = SCAN_IDLE;
      ended = scan_between(c);
    end
    if (!ended) offset = add_sat(offset, 1);
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endtask

  // Sends one source byte, with random gaps before it while idling is on.
  task automatic send_byte(logic [7:0] c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.source_byte <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_tokens(c);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Receiver stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_out) out_ch.ready <= 1'b0;
    else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 14) - 1) @(negedge clk);
    end else out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    token_t got, exp_tok;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind = out_ch.token_kind; got.err = out_ch.error_code;
      got.start = out_ch.token_start; got.len = out_ch.token_length;
      got.line = out_ch.token_line; got.last = out_ch.last_of_run;
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token, actual %p", $time, got);
        fail_count++;
      end else begin
        exp_tok = pending_tokens.pop_front();
        if (got !== exp_tok) begin
          $display("%0t: token mismatch, expected %p, actual %p", $time, exp_tok, got);
          fail_count++;
        end
      end
    end
  end

  task automatic test_operators();
    send_text("( ) { } ; , . - -> + / * ! != = == < <= > >= @ // note\n");
    send_byte(8'hFF);
    send_byte(0);
  endtask

  task automatic test_words_numbers();
    send_text("and class else false for function if nil or print return super this ");
    send_text("true var while when functions _x9 12.5 7. 3.x 42");
    send_byte(0);
  endtask

  task automatic test_strings();
    send_text("\"a\nb\" \"x$(f(1)) y\" \"$q\" \"$\n\" \"$");
    send_byte(0);
    send_text("\"open");
    send_byte(0);
    // Nine nested interpolations: the ninth is too deep.
    for (int i = 0; i < 9; i++) send_text("\"$(");
    send_text("\"$ )))))))))");
    send_byte(0);
  endtask

  function automatic logic [7:0] pick_char();
    string pool = "abcwhenforif_019.;,(){}+-*/!=<> \n\"$";
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(1, 255));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // Sends about n source bytes of random text.
  task automatic test_random(int n);
    int k;
    while (n > 0) begin
      k = $urandom_range(3, 30);
      for (int i = 0; i < k && n > 0; i++) begin
        case ($urandom_range(0, 5))
          0: begin
            send_text("\"s$(x)t\"");
            n -= 8;
          end
          1: begin
            send_text("while (a >= 1.25) ");
            n -= 18;
          end
          default: begin
            send_byte(pick_char());
            n--;
          end
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        send_byte(0);
        n--;
      end
    end
    send_byte(0);
  endtask

  task automatic test_backpressure();
    hold_out = 1'b1;
    fork
      send_text("( ) ; , + * { } . ; ( )");
      begin
        repeat (60) @(negedge clk);
        hold_out = 1'b0;
      end
    join
    send_byte(0);
  endtask

  initial begin
    fail_count = 0; idle_on = 1'b1; hold_out = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.source_byte = 8'd0;
    clear_scanner();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_operators();
    test_words_numbers();
    test_strings();
    test_backpressure();
    test_random(130);
    idle_on = 1'b0;
    test_random(55);
    in_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
sv/stsc_pkg.sv
sv/stsc_if.sv
sv/stsc_core.sv
sv/stsc_out_fifo.sv
sv/source_token_scanner_unit.sv
tb/testbench.sv
